@@ rtl/pfe_pkg.sv @@
package pfe_pkg;

   // letter codes and key square geometry
   localparam int LETTER_W    = 5;
   localparam int SQUARE_SIDE = 5;
   localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
   localparam int IDX_W       = $clog2(SQUARE_SIDE);

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [IDX_W-1:0]    idx_type;

   localparam letter_type LETTER_I      = letter_type'(8);
   localparam letter_type LETTER_J      = letter_type'(9);
   localparam letter_type FILLER_RESET  = letter_type'(23);

   // register file layout
   localparam int ROWS_W     = 2 * SQUARE_SIDE * LETTER_W;
   localparam int ROW_W      = SQUARE_SIDE * LETTER_W;
   localparam int CFG_DATA_W = 64;
   localparam int CFG_ADDR_W = 5;
   localparam int REG_IDX_W  = 2;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_ROWS_A = 2'd0;
   localparam reg_idx_type REG_ROWS_B = 2'd1;
   localparam reg_idx_type REG_ROW_C  = 2'd2;
   localparam reg_idx_type REG_FILLER = 2'd3;

   // one enciphered pair
   typedef struct packed {
      letter_type c0;
      letter_type c1;
      logic       miss;
   } pair_out_type;

   // fold J onto I
   function automatic letter_type fold(input letter_type c);
      return (c == LETTER_J) ? LETTER_I : c;
   endfunction

endpackage

@@ rtl/pfe_channels.sv @@
interface pfe_req_if
   import pfe_pkg::*;
();
   logic       valid;
   logic       ready;
   letter_type letter;
   logic       end_of_text;

   modport source (output valid, letter, end_of_text, input ready);
   modport sink (input valid, letter, end_of_text, output ready);
endinterface

interface pfe_rsp_if
   import pfe_pkg::*;
();
   logic       valid;
   logic       ready;
   letter_type cipher_letter;
   logic       last_of_run;
   logic       end_of_message;
   logic       not_found;

   modport source (output valid, cipher_letter, last_of_run, end_of_message, not_found,
                   input ready);
   modport sink (input valid, cipher_letter, last_of_run, end_of_message, not_found,
                 output ready);
endinterface

@@ rtl/pfe_pair.sv @@
module pfe_pair
   import pfe_pkg::*;
(
   input  logic [CELLS*LETTER_W-1:0] square,
   input  letter_type                a,
   input  letter_type                b,
   output pair_out_type              result
);

   typedef struct packed {
      logic    found;
      idx_type row;
      idx_type col;
   } pos_type;

   letter_type grid [SQUARE_SIDE][SQUARE_SIDE];
   pos_type    pos_a;
   pos_type    pos_b;
   idx_type    row_a_nx;
   idx_type    row_b_nx;
   idx_type    col_a_nx;
   idx_type    col_b_nx;

   // unpack the square, row-major
   always_comb begin
      for (int r = 0; r < SQUARE_SIDE; r++) begin
         for (int c = 0; c < SQUARE_SIDE; c++) begin
            grid[r][c] = square[(r*SQUARE_SIDE + c)*LETTER_W +: LETTER_W];
         end
      end
   end

   // first match in row-major order wins, so scan backwards
   function automatic pos_type locate(input letter_type key,
                                      input logic [CELLS*LETTER_W-1:0] sq);
      pos_type p;
      p = '0;
      for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
         for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
            if (sq[(r*SQUARE_SIDE + c)*LETTER_W +: LETTER_W] == key) begin
               p.found = 1'b1;
               p.row   = idx_type'(r);
               p.col   = idx_type'(c);
            end
         end
      end
      return p;
   endfunction

   assign pos_a = locate(a, square);
   assign pos_b = locate(b, square);

   // cyclic neighbors
   assign row_a_nx = (pos_a.row == idx_type'(SQUARE_SIDE - 1)) ? '0 : pos_a.row + idx_type'(1);
   assign row_b_nx = (pos_b.row == idx_type'(SQUARE_SIDE - 1)) ? '0 : pos_b.row + idx_type'(1);
   assign col_a_nx = (pos_a.col == idx_type'(SQUARE_SIDE - 1)) ? '0 : pos_a.col + idx_type'(1);
   assign col_b_nx = (pos_b.col == idx_type'(SQUARE_SIDE - 1)) ? '0 : pos_b.col + idx_type'(1);

   // same row, same column or rectangle
   always_comb begin
      result.miss = !(pos_a.found && pos_b.found);
      result.c0   = '0;
      result.c1   = '0;
      if (!result.miss) begin
         if (pos_a.row == pos_b.row) begin
            result.c0 = grid[pos_a.row][col_a_nx];
            result.c1 = grid[pos_b.row][col_b_nx];
         end else if (pos_a.col == pos_b.col) begin
            result.c0 = grid[row_a_nx][pos_a.col];
            result.c1 = grid[row_b_nx][pos_b.col];
         end else begin
            result.c0 = grid[pos_a.row][pos_b.col];
            result.c1 = grid[pos_b.row][pos_a.col];
         end
      end
   end

endmodule

@@ rtl/playfair_digraph_encrypt.sv @@
// Playfair digraph encryptor over a 5x5 key square set by registers. A letter is
// taken on every cycle that the request register is free; a request that completes
// a pair gives two results, a doubled letter at end of text gives four, and a lone
// letter not at end of text gives none. Results leave one per cycle while the output
// port is ready, so the output port sets the sustained rate. A request passes through
// the request register, then the result register, and a new request is taken while
// earlier results still wait. Square lookups are parallel compares against all 25
// entries. The square and filler must be written over APB only while the block is
// idle; the block itself does not enforce this.
module playfair_digraph_encrypt
   import pfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [CFG_DATA_W-1:0] pwdata,
   output logic [CFG_DATA_W-1:0] prdata,
   output logic                  pready,
   pfe_req_if.sink               req_if,
   pfe_rsp_if.source             rsp_if
);

   typedef struct packed {
      letter_type a0;
      letter_type b0;
      letter_type a1;
      letter_type b1;
      logic       last0;
      logic       eom0;
      logic       two;
   } job_type;

   logic [ROWS_W-1:0] rows_a_ff;
   logic [ROWS_W-1:0] rows_b_ff;
   logic [ROW_W-1:0]  row_c_ff;
   letter_type        filler_ff;
   reg_idx_type       reg_idx;
   logic              wr_en;

   logic              pend_v_ff, pend_v_in;
   letter_type        pend_ff, pend_in;
   letter_type        c_in;
   letter_type        fill;
   logic              has_out;
   logic              req_fire;

   logic              s1_v_ff;
   job_type           s1_job_ff, s1_job_in;
   logic              s1_move;

   pair_out_type      pair0;
   pair_out_type      pair1;

   logic              s2_v_ff;
   logic              two_ff;
   logic [1:0]        idx_ff;
   letter_type        res_letter_ff [4];
   logic [3:0]        res_nf_ff;
   logic [3:0]        res_last_ff;
   logic [3:0]        res_eom_ff;
   logic              rsp_fire;
   logic              s2_done;
   logic              s2_free;

   // configuration registers
   assign pready  = 1'b1;
   assign reg_idx = paddr[CFG_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= '0;
         rows_b_ff <= '0;
         row_c_ff  <= '0;
         filler_ff <= FILLER_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ROWS_A: rows_a_ff <= pwdata[ROWS_W-1:0];
            REG_ROWS_B: rows_b_ff <= pwdata[ROWS_W-1:0];
            REG_ROW_C:  row_c_ff  <= pwdata[ROW_W-1:0];
            REG_FILLER: filler_ff <= pwdata[LETTER_W-1:0];
            default:    ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_idx)
         REG_ROWS_A: prdata = CFG_DATA_W'(rows_a_ff);
         REG_ROWS_B: prdata = CFG_DATA_W'(rows_b_ff);
         REG_ROW_C:  prdata = CFG_DATA_W'(row_c_ff);
         REG_FILLER: prdata = CFG_DATA_W'(filler_ff);
         default:    prdata = '0;
      endcase
   end

   // pairing of incoming letters
   assign c_in     = fold(req_if.letter);
   assign fill     = fold(filler_ff);
   assign req_fire = req_if.valid && req_if.ready;

   always_comb begin
      s1_job_in       = '0;
      s1_job_in.last0 = 1'b1;
      has_out         = 1'b1;
      pend_v_in       = 1'b0;
      pend_in         = '0;
      if (!pend_v_ff) begin
         s1_job_in.a0   = c_in;
         s1_job_in.b0   = fill;
         s1_job_in.eom0 = 1'b1;
         if (!req_if.end_of_text) begin
            has_out   = 1'b0;
            pend_v_in = 1'b1;
            pend_in   = c_in;
         end
      end else if (c_in == pend_ff) begin
         // doubled letter: filler goes in, letter stays pending unless the text ends
         s1_job_in.a0    = pend_ff;
         s1_job_in.b0    = fill;
         s1_job_in.last0 = !req_if.end_of_text;
         s1_job_in.a1    = c_in;
         s1_job_in.b1    = fill;
         s1_job_in.two   = req_if.end_of_text;
         if (!req_if.end_of_text) begin
            pend_v_in = 1'b1;
            pend_in   = c_in;
         end
      end else begin
         s1_job_in.a0   = pend_ff;
         s1_job_in.b0   = c_in;
         s1_job_in.eom0 = req_if.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         pend_ff   <= '0;
      end else if (req_fire) begin
         pend_v_ff <= pend_v_in;
         pend_ff   <= pend_in;
      end
   end

   // request register
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign s2_done  = rsp_fire && (idx_ff == {two_ff, 1'b1});
   assign s2_free  = !s2_v_ff || s2_done;
   assign s1_move  = s1_v_ff && s2_free;
   assign req_if.ready = !s1_v_ff || s2_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_fire) begin
         s1_v_ff <= has_out;
      end else if (s1_move) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_job_ff <= s1_job_in;
      end
   end

   // encipher both pairs
   pfe_pair u_pair0 (
      .square ({row_c_ff, rows_b_ff, rows_a_ff}),
      .a      (s1_job_ff.a0),
      .b      (s1_job_ff.b0),
      .result (pair0)
   );

   pfe_pair u_pair1 (
      .square ({row_c_ff, rows_b_ff, rows_a_ff}),
      .a      (s1_job_ff.a1),
      .b      (s1_job_ff.b1),
      .result (pair1)
   );

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         two_ff  <= 1'b0;
         idx_ff  <= '0;
      end else if (s1_move) begin
         s2_v_ff <= 1'b1;
         two_ff  <= s1_job_ff.two;
         idx_ff  <= '0;
      end else if (s2_done) begin
         s2_v_ff <= 1'b0;
      end else if (rsp_fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         res_letter_ff[0] <= pair0.c0;
         res_letter_ff[1] <= pair0.c1;
         res_letter_ff[2] <= pair1.c0;
         res_letter_ff[3] <= pair1.c1;
         res_nf_ff        <= {pair1.miss, pair1.miss, pair0.miss, pair0.miss};
         res_last_ff      <= {1'b1, 1'b0, s1_job_ff.last0, 1'b0};
         res_eom_ff       <= {1'b1, 1'b0, s1_job_ff.eom0, 1'b0};
      end
   end

   assign rsp_if.valid          = s2_v_ff;
   assign rsp_if.cipher_letter  = res_letter_ff[idx_ff];
   assign rsp_if.last_of_run    = res_last_ff[idx_ff];
   assign rsp_if.end_of_message = res_eom_ff[idx_ff];
   assign rsp_if.not_found      = res_nf_ff[idx_ff];

`ifndef ASSERT_OFF
   // a result that is not the last of its request is followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_if.last_of_run |=> rsp_if.valid)
      else $error("result run ended early");

   // a blocked request register keeps its pair
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_free |=> s1_v_ff && $stable(s1_job_ff))
      else $error("request register lost its pair");

   // a single pair never walks past its second result
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !two_ff |-> !idx_ff[1])
      else $error("result index past single pair");
`endif

endmodule
